[hw/rtl/tgarle_pkg.sv]
// Shared types, constants and helpers for the TGA run-length pixel decoder.
package tgarle_pkg;

  localparam logic [7:0]  RLE_THRESHOLD   = 8'd127;
  localparam logic [31:0] PIXEL_INIT      = 32'hFF00_0000;
  localparam logic [2:0]  BPP_RESET       = 3'd4;
  localparam logic [15:0] ROW_WIDTH_RESET = 16'd1;
  localparam int          QUEUE_DEPTH     = 2;

  // Configuration register indexes
  typedef enum logic [0:0] {
    CFG_BYTES_PER_PIXEL = 1'b0,
    CFG_ROW_WIDTH       = 1'b1
  } cfg_index_t;

  // One complete pixel as handed from the front end to the back end
  typedef struct packed {
    logic [31:0] pixel_word;
    logic [7:0]  pixels_left;  // pixels left in the packet, this one included
    logic        run_packet;
    logic        packet_end;
    logic        clear_cols;   // a frame start came before this pixel
  } queue_entry_t;

  typedef struct packed {
    logic         valid;
    queue_entry_t entry;
  } queue_slot_t;

  // Byte count at which a pixel completes, modulo 4 (0 means four bytes)
  function automatic logic [1:0] pixel_end_mark(input logic [2:0] bytes_per_pixel);
    logic [1:0] mark;
    case (bytes_per_pixel)
      3'd0:    mark = 2'd1;
      3'd1:    mark = 2'd1;
      3'd2:    mark = 2'd2;
      3'd3:    mark = 2'd3;
      default: mark = 2'd0;
    endcase
    return mark;
  endfunction

endpackage

[hw/rtl/tgarle_if.sv]
// Valid/ready channel interfaces for compressed bytes in and decoded pixels out.
interface tgarle_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, output data_byte, output frame_start, input ready);
  modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface tgarle_pixel_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_value;
  logic [7:0]  run_length;
  logic        row_last;
  logic        overrun;

  modport source (output valid, output pixel_value, output run_length,
                  output row_last, output overrun, input ready);
  modport sink   (input valid, input pixel_value, input run_length,
                  input row_last, input overrun, output ready);
endinterface

[hw/rtl/tgarle_front.sv]
// Front end: parses packet headers and assembles pixel bytes into words.
module tgarle_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [2:0]               bytes_per_pixel,
  tgarle_byte_if.sink              byte_in,
  input  logic                     q_full,
  output tgarle_pkg::queue_slot_t  push
);

  logic        expect_header, expect_header_next;
  logic        run_packet, run_packet_next;
  logic [7:0]  pixels_left, pixels_left_next;
  logic [1:0]  byte_index, byte_index_next;
  logic [31:0] pixel_word, pixel_word_next;
  logic        clear_pending, clear_pending_next;

  logic        accept;
  logic        eff_header, eff_run, eff_clear;
  logic [7:0]  eff_left;
  logic [1:0]  eff_index, index_inc;
  logic [31:0] eff_word, word_new;
  logic        pixel_done, packet_end;

  assign byte_in.ready = !q_full;
  assign accept        = byte_in.valid && byte_in.ready;

  // Apply a frame start before the byte is looked at
  always_comb begin
    if (byte_in.frame_start) begin
      eff_header = 1'b1;
      eff_run    = 1'b0;
      eff_left   = 8'd0;
      eff_index  = 2'd0;
      eff_word   = tgarle_pkg::PIXEL_INIT;
      eff_clear  = 1'b1;
    end else begin
      eff_header = expect_header;
      eff_run    = run_packet;
      eff_left   = pixels_left;
      eff_index  = byte_index;
      eff_word   = pixel_word;
      eff_clear  = clear_pending;
    end
  end

  // Drop the byte into its lane of the pixel word
  always_comb begin
    word_new = eff_word;
    for (int lane = 0; lane < 4; lane++) begin
      if (eff_index == 2'(lane)) begin
        word_new[lane*8 +: 8] = byte_in.data_byte;
      end
    end
  end

  assign index_inc  = eff_index + 2'd1;
  assign pixel_done = !eff_header && (index_inc == tgarle_pkg::pixel_end_mark(bytes_per_pixel));
  assign packet_end = eff_run || (eff_left <= 8'd1);

  // Next state of the parser
  always_comb begin
    expect_header_next = expect_header;
    run_packet_next    = run_packet;
    pixels_left_next   = pixels_left;
    byte_index_next    = byte_index;
    pixel_word_next    = pixel_word;
    clear_pending_next = clear_pending;
    if (accept) begin
      run_packet_next    = eff_run;
      pixels_left_next   = eff_left;
      clear_pending_next = eff_clear;
      if (eff_header) begin
        run_packet_next    = byte_in.data_byte > tgarle_pkg::RLE_THRESHOLD;
        pixels_left_next   = (byte_in.data_byte > tgarle_pkg::RLE_THRESHOLD)
                             ? byte_in.data_byte - tgarle_pkg::RLE_THRESHOLD
                             : byte_in.data_byte + 8'd1;
        byte_index_next    = 2'd0;
        expect_header_next = 1'b0;
        pixel_word_next    = eff_word;
      end else begin
        pixel_word_next    = word_new;
        expect_header_next = 1'b0;
        if (pixel_done) begin
          byte_index_next    = 2'd0;
          clear_pending_next = 1'b0;
          if (packet_end) begin
            pixels_left_next   = 8'd0;
            expect_header_next = 1'b1;
          end else begin
            pixels_left_next = eff_left - 8'd1;
          end
        end else begin
          byte_index_next = index_inc;
        end
      end
    end
  end

  // Hand a finished pixel to the queue
  always_comb begin
    push.valid             = accept && pixel_done;
    push.entry.pixel_word  = word_new;
    push.entry.pixels_left = eff_left;
    push.entry.run_packet  = eff_run;
    push.entry.packet_end  = packet_end;
    push.entry.clear_cols  = eff_clear;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      expect_header <= 1'b1;
      run_packet    <= 1'b0;
      pixels_left   <= 8'd0;
      byte_index    <= 2'd0;
      pixel_word    <= tgarle_pkg::PIXEL_INIT;
      clear_pending <= 1'b0;
    end else begin
      expect_header <= expect_header_next;
      run_packet    <= run_packet_next;
      pixels_left   <= pixels_left_next;
      byte_index    <= byte_index_next;
      pixel_word    <= pixel_word_next;
      clear_pending <= clear_pending_next;
    end
  end

endmodule

[hw/rtl/tgarle_queue.sv]
// Short pixel queue that lets the front and back ends stall independently.
module tgarle_queue #(
  parameter int DEPTH = tgarle_pkg::QUEUE_DEPTH
) (
  input  logic                     clk,
  input  logic                     rst,
  input  tgarle_pkg::queue_slot_t  push,
  input  logic                     pop,
  output tgarle_pkg::queue_slot_t  head,
  output logic                     full
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  tgarle_pkg::queue_entry_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [CW-1:0] count;
  logic          do_push, do_pop;

  assign full       = (count == CW'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.entry;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (!do_push && do_pop) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[hw/rtl/tgarle_back.sv]
// Back end: counts columns, flags row ends and overruns, holds the output word.
module tgarle_back (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [15:0]              row_width,
  input  tgarle_pkg::queue_slot_t  head,
  output logic                     pop,
  tgarle_pixel_if.source           pixel_out
);

  logic [15:0] column_count;
  logic        out_valid;
  logic [31:0] out_value;
  logic [7:0]  out_run;
  logic        out_last, out_over;

  logic [15:0] col;
  logic [16:0] reach, next_col;
  logic [7:0]  count;
  logic        over, last;

  assign pop = head.valid && (!out_valid || pixel_out.ready);

  // Work out row position for the pixel at the head of the queue
  always_comb begin
    col      = head.entry.clear_cols ? 16'd0 : column_count;
    reach    = {1'b0, col} + {9'd0, head.entry.pixels_left};
    over     = reach > {1'b0, row_width};
    count    = head.entry.run_packet ? head.entry.pixels_left : 8'd1;
    next_col = {1'b0, col} + {9'd0, count};
    last     = head.entry.packet_end && (next_col >= {1'b0, row_width});
  end

  // Load the output word
  always_ff @(posedge clk) begin
    if (pop) begin
      out_value <= head.entry.pixel_word;
      out_run   <= count;
      out_last  <= last;
      out_over  <= over;
    end
  end

  // Hold column count and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= 16'd0;
      out_valid    <= 1'b0;
    end else begin
      if (pop) begin
        if (last) begin
          column_count <= 16'd0;
        end else begin
          column_count <= next_col[16] ? 16'hFFFF : next_col[15:0];
        end
        out_valid <= 1'b1;
      end else if (pixel_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign pixel_out.valid       = out_valid;
  assign pixel_out.pixel_value = out_value;
  assign pixel_out.run_length  = out_run;
  assign pixel_out.row_last    = out_last;
  assign pixel_out.overrun     = out_over;

endmodule

[hw/rtl/tga_rle_pixel_decoder_unit.sv]
// Top level of the TGA run-length pixel decoder with its configuration registers.
//
// Takes one compressed byte per clock and delivers one word per decoded pixel,
// carrying the pixel value, its run length and row-end and overrun flags.
// Header bytes and bytes that do not finish a pixel produce no word. A pixel
// word is written by the front end into a QUEUE_DEPTH-entry queue, and the
// back end moves it into the output register. Input ready falls only while
// the queue is full, so with the output taken every cycle the decoder
// sustains one byte per cycle. Configuration is written through
// cfg_we/cfg_index/cfg_data; the user must do so only while the decoder is
// idle, as the block itself does not enforce it.
module tga_rle_pixel_decoder_unit #(
  parameter int QUEUE_DEPTH = tgarle_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst,
  tgarle_byte_if.sink    byte_in,
  tgarle_pixel_if.source pixel_out,
  input  logic           cfg_we,
  input  logic [0:0]     cfg_index,
  input  logic [15:0]    cfg_data
);

  logic [2:0]  bytes_per_pixel;
  logic [15:0] row_width;

  tgarle_pkg::queue_slot_t push, head;
  logic                    pop, q_full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_pixel <= tgarle_pkg::BPP_RESET;
      row_width       <= tgarle_pkg::ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tgarle_pkg::CFG_BYTES_PER_PIXEL: bytes_per_pixel <= cfg_data[2:0];
        tgarle_pkg::CFG_ROW_WIDTH:       row_width       <= cfg_data;
        default: ;
      endcase
    end
  end

  tgarle_front u_front (
    .clk             (clk),
    .rst             (rst),
    .bytes_per_pixel (bytes_per_pixel),
    .byte_in         (byte_in),
    .q_full          (q_full),
    .push            (push)
  );

  tgarle_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .pop  (pop),
    .head (head),
    .full (q_full)
  );

  tgarle_back u_back (
    .clk       (clk),
    .rst       (rst),
    .row_width (row_width),
    .head      (head),
    .pop       (pop),
    .pixel_out (pixel_out)
  );

endmodule

[sim/testbench.sv]
// Self-checking testbench for the TGA run-length pixel decoder unit.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int HOLD_CYCLES = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int DRAIN_GAP   = 4;

  // One decoded pixel word as seen on the output channel
  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic        row_last;
    logic        overrun;
  } pixel_word_t;

  // Scoreboard: tracks the decoder state and queues the pixels it should emit
  class pixel_scoreboard;
    logic [2:0]  bpp;
    logic [15:0] row_width;
    bit          header_due;
    bit          run_packet;
    int          pixels_left;
    logic [1:0]  byte_pos;
    logic [31:0] pixel_acc;
    int          column;
    pixel_word_t pending_pixels[$];
    int          mismatches;
    int          pixels_checked;

    function new();
      bpp            = tgarle_pkg::BPP_RESET;
      row_width      = tgarle_pkg::ROW_WIDTH_RESET;
      mismatches     = 0;
      pixels_checked = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      header_due  = 1'b1;
      run_packet  = 1'b0;
      pixels_left = 0;
      byte_pos    = 2'd0;
      pixel_acc   = tgarle_pkg::PIXEL_INIT;
      column      = 0;
    endfunction

    // Bytes that make up one pixel at the current size setting
    function int pixel_bytes();
      if (bpp == 3'd0) return 1;
      if (bpp > 3'd4) return 4;
      return int'(bpp);
    endfunction

    function void configure(tgarle_pkg::cfg_index_t idx, logic [15:0] value);
      if (idx == tgarle_pkg::CFG_BYTES_PER_PIXEL) bpp = value[2:0];
      else row_width = value;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 40) $display("MISMATCH: %s", msg);
    endfunction

    function int outstanding();
      return pending_pixels.size();
    endfunction

    // Advance the decoder by one accepted byte word
    function void note_byte(logic [7:0] b, logic fs);
      int          reach;
      int          count;
      int          next_col;
      bit          packet_end;
      pixel_word_t p;
      if (fs) clear_frame();
      if (header_due) begin
        run_packet  = b > tgarle_pkg::RLE_THRESHOLD;
        pixels_left = run_packet ? int'(b) - int'(tgarle_pkg::RLE_THRESHOLD) : int'(b) + 1;
        byte_pos    = 2'd0;
        header_due  = 1'b0;
        return;
      end
      pixel_acc[byte_pos*8 +: 8] = b;
      byte_pos = byte_pos + 2'd1;
      if (byte_pos != 2'(pixel_bytes())) return;
      byte_pos = 2'd0;

      reach    = column + pixels_left;
      count    = run_packet ? pixels_left : 1;
      next_col = column + count;
      packet_end = run_packet || pixels_left <= 1;
      if (packet_end) begin
        pixels_left = 0;
        header_due  = 1'b1;
      end else begin
        pixels_left--;
      end

      p.pixel_value = pixel_acc;
      p.run_length  = 8'(count);
      p.overrun     = reach > int'(row_width);
      p.row_last    = packet_end && next_col >= int'(row_width);
      // column count holds at its top value inside an over-long literal group
      if (p.row_last) column = 0;
      else column = (next_col > 65535) ? 65535 : next_col;
      pending_pixels.push_back(p);
    endfunction

    function void check_pixel(pixel_word_t got);
      pixel_word_t want;
      if (pending_pixels.size() == 0) begin
        report($sformatf("pixel %h arrived with none pending", got.pixel_value));
        return;
      end
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (got.pixel_value !== want.pixel_value)
        report($sformatf("pixel #%0d value %h, want %h", pixels_checked,
                         got.pixel_value, want.pixel_value));
      if (got.run_length !== want.run_length)
        report($sformatf("pixel #%0d run length %0d, want %0d", pixels_checked,
                         got.run_length, want.run_length));
      if (got.row_last !== want.row_last)
        report($sformatf("pixel #%0d row end %b, want %b", pixels_checked,
                         got.row_last, want.row_last));
      if (got.overrun !== want.overrun)
        report($sformatf("pixel #%0d overrun %b, want %b", pixels_checked,
                         got.overrun, want.overrun));
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst;
  logic                   cfg_we;
  tgarle_pkg::cfg_index_t cfg_index;
  logic [15:0]            cfg_data;

  tgarle_byte_if  byte_bus();
  tgarle_pixel_if pixel_bus();

  pixel_scoreboard sb;
  int bytes_sent;
  int settings_used;
  int sender_idle_pct;
  int recv_idle_pct;
  int holds_requested;
  int stall_cycles;

  tga_rle_pixel_decoder_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_bus),
    .pixel_out (pixel_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Sample both channels mid-cycle: a word seen here is taken at the next edge
  initial begin
    pixel_word_t got;
    stall_cycles = 0;
    forever begin
      @(negedge clk);
      if (!rst && byte_bus.valid && byte_bus.ready)
        sb.note_byte(byte_bus.data_byte, byte_bus.frame_start);
      if (!rst && pixel_bus.valid && pixel_bus.ready) begin
        got.pixel_value = pixel_bus.pixel_value;
        got.run_length  = pixel_bus.run_length;
        got.row_last    = pixel_bus.row_last;
        got.overrun     = pixel_bus.overrun;
        sb.check_pixel(got);
      end
      if ((byte_bus.valid && byte_bus.ready) || (pixel_bus.valid && pixel_bus.ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
  end

  // Watchdog: give up once nothing has moved for too long
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Timeout: no word moved for %0d cycles", STALL_LIMIT);
    $display("Verification failed");
    $finish;
  end

  // Receiver: random back-pressure, plus long hold-offs on request
  initial begin
    int   holds_served;
    int   hold_left;
    logic rdy;
    holds_served    = 0;
    hold_left       = 0;
    pixel_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_requested) begin
        holds_served++;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else begin
        rdy = $urandom_range(99) >= recv_idle_pct;
      end
      pixel_bus.ready <= rdy;
    end
  end

  // Receiver idles first, sender next, then neither
  function void set_idle_mode();
    if (bytes_sent < 550) begin
      sender_idle_pct = 17;
      recv_idle_pct   = 75;
    end else if (bytes_sent < 1100) begin
      sender_idle_pct = 75;
      recv_idle_pct   = 17;
    end else begin
      sender_idle_pct = 0;
      recv_idle_pct   = 0;
    end
  endfunction

  // Offer one byte word and hold it until taken
  task automatic send_byte(input logic [7:0] b, input logic fs);
    while ($urandom_range(99) < sender_idle_pct) begin
      byte_bus.valid <= 1'b0;
      @(posedge clk);
    end
    byte_bus.valid       <= 1'b1;
    byte_bus.data_byte   <= b;
    byte_bus.frame_start <= fs;
    @(negedge clk);
    while (!byte_bus.ready) @(negedge clk);
    @(posedge clk);
    bytes_sent++;
    set_idle_mode();
  endtask

  // Header plus random pixel bytes for a whole packet
  task automatic send_packet(input bit run, input int count, input logic fs);
    logic [7:0] hdr;
    int         nbytes;
    hdr    = run ? 8'(count + 127) : 8'(count - 1);
    nbytes = (run ? 1 : count) * sb.pixel_bytes();
    send_byte(hdr, fs);
    repeat (nbytes) send_byte(8'($urandom), 1'b0);
  endtask

  // Stop offering until every pending pixel is out, then let the pipe settle
  task automatic drain();
    byte_bus.valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input tgarle_pkg::cfg_index_t idx, input logic [15:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.configure(idx, value);
    @(posedge clk);
  endtask

  task automatic set_config(input logic [2:0] bpp, input logic [15:0] width);
    drain();
    // upper data bits are don't-care for the pixel size register
    write_reg(tgarle_pkg::CFG_BYTES_PER_PIXEL, {13'($urandom), bpp});
    write_reg(tgarle_pkg::CFG_ROW_WIDTH, width);
    settings_used++;
  endtask

  // Mostly whole packets; some cut short, some stray bytes
  task automatic random_phase(input int items);
    int   first;
    int   kind;
    int   count;
    int   lit_max;
    bit   run;
    logic fs;
    first = bytes_sent;
    fs    = 1'b1;
    while (bytes_sent - first < items) begin
      kind = $urandom_range(99);
      if (kind < 85) begin
        run     = $urandom_range(1);
        lit_max = (sb.pixel_bytes() == 1) ? 128 : 24;
        if (run) count = $urandom_range(1, 128);
        else if ($urandom_range(9) == 0) count = $urandom_range(1, lit_max);
        else count = $urandom_range(1, 4);
        send_packet(run, count, fs);
        fs = 1'b0;
      end else if (kind < 93) begin
        send_byte(8'($urandom), fs);
        repeat ($urandom_range(2)) send_byte(8'($urandom), 1'b0);
        fs = 1'b1;
      end else begin
        send_byte(8'($urandom), 1'($urandom_range(3) == 0));
        fs = 1'($urandom_range(1));
      end
    end
  endtask

  task automatic run_phase(input logic [2:0] bpp, input logic [15:0] width,
                           input int items);
    set_config(bpp, width);
    random_phase(items);
  endtask

  // Hand-picked packets: extremes, both packet kinds, restart mid-packet
  task automatic directed_phase();
    set_config(3'd1, 16'd4);
    send_byte(8'h00, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h81, 1'b0);
    send_byte(8'h5A, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h01, 1'b0);
    send_byte(8'h02, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hA5, 1'b0);
    send_byte(8'h03, 1'b0);
    send_byte(8'h11, 1'b0);
    send_byte(8'h80, 1'b1);
    send_byte(8'hC3, 1'b0);
  endtask

  // Walk the column count up to its top value with full runs, then overrun it
  task automatic long_row_phase();
    set_config(3'd1, 16'hFFFF);
    send_packet(1'b1, 128, 1'b1);
    repeat (510) send_packet(1'b1, 128, 1'b0);
    send_packet(1'b1, 92, 1'b0);
    send_packet(1'b0, 128, 1'b0);
    send_packet(1'b0, 3, 1'b0);
  endtask

  // Block the output while bytes keep coming, then wait for all pixels
  task automatic pressure_burst();
    holds_requested++;
    send_packet(1'b1, $urandom_range(1, 128), 1'b1);
    repeat (15) send_packet(1'b1, $urandom_range(1, 128), 1'b0);
    drain();
  endtask

  initial begin
    sb                   = new();
    bytes_sent           = 0;
    settings_used        = 0;
    holds_requested      = 0;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = tgarle_pkg::CFG_BYTES_PER_PIXEL;
    cfg_data             = 16'd0;
    byte_bus.valid       = 1'b0;
    byte_bus.data_byte   = 8'd0;
    byte_bus.frame_start = 1'b0;
    set_idle_mode();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings first: four-byte pixels, one-pixel rows
    random_phase(24);
    directed_phase();
    run_phase(3'd3, 16'd5, 24);
    run_phase(3'd4, 16'd0, 24);
    run_phase(3'd0, 16'd3, 24);
    run_phase(3'd2, 16'd7, 24);
    run_phase(3'($urandom_range(5, 7)), 16'd16, 24);
    long_row_phase();
    run_phase(3'd3, 16'($urandom_range(1, 40)), 24);
    pressure_burst();
    run_phase(3'd1, 16'd1, 24);
    run_phase(3'd7, 16'hFFFF, 24);

    drain();
    $display("Covered %0d compressed bytes and %0d decoded pixels", bytes_sent,
             sb.pixels_checked);
    $display("across %0d register settings, with stalls on both channels",
             settings_used);
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Verification failed");
    end
    $finish;
  end

endmodule
